// File: design/isre_pkg.sv
// ---------------------------------------------------------------------------
// isre_pkg
// shared constants, operation codes and unit interface types for the
// i2c sensor register emulator
// ---------------------------------------------------------------------------
package isre_pkg;

    localparam int C_OP_W       = 3;
    localparam int C_ADDR_W     = 7;
    localparam int C_BYTE_W     = 8;
    localparam int C_CODE_W     = 14;
    localparam int C_WORD_W     = 16;
    localparam int C_SEED_W     = 32;
    localparam int C_FILE_BYTES = 8;
    localparam int C_IDX_W      = $clog2(C_FILE_BYTES);
    localparam int C_WIDX_W     = C_IDX_W - 1;
    localparam int C_FOLD_STEPS = 5;
    localparam int C_CNT_W      = $clog2(C_FOLD_STEPS);
    localparam int C_FOLD_SHIFT = 11;
    localparam int C_XY_FOLD    = 15;

    localparam logic [C_OP_W-1:0] OP_CONNECT    = 3'd0;
    localparam logic [C_OP_W-1:0] OP_READ       = 3'd1;
    localparam logic [C_OP_W-1:0] OP_WRITE      = 3'd2;
    localparam logic [C_OP_W-1:0] OP_DISCONNECT = 3'd3;
    localparam logic [C_OP_W-1:0] OP_FRAME_END  = 3'd4;

    localparam logic [C_SEED_W-1:0] C_LCG_MUL    = 32'd1664525;
    localparam logic [C_SEED_W-1:0] C_LCG_ADD    = 32'd1013904223;
    localparam logic [C_SEED_W-1:0] C_SEED_RESET = 32'hDEADBEEF;

    // moduli are 2*span+1, offsets fold the span and the 1 g bias
    localparam logic [C_WORD_W-1:0] C_XY_MOD = 16'd32769;
    localparam logic [C_WORD_W-1:0] C_Z_MOD  = 16'd2001;
    localparam logic [C_WORD_W-1:0] C_XY_OFS = 16'd16384;
    localparam logic [C_WORD_W-1:0] C_Z_OFS  = 16'd15384;

    // 2^11 is 47 mod 2001, 2^15 is -1 mod 32769
    localparam logic [C_SEED_W-1:0] C_FOLD_MUL = 32'd47;

    localparam logic [C_ADDR_W-1:0] C_ADDR_RESET = 7'h68;
    localparam logic [C_BYTE_W-1:0] C_PAST_END   = 8'hFF;
    localparam logic [C_CNT_W-1:0]  C_CNT_LAST   = C_CNT_W'(C_FOLD_STEPS - 1);

    typedef struct packed {
        logic start;
        logic z_axis;
    } t_noise_req;

    typedef struct packed {
        logic                done;
        logic [C_WORD_W-1:0] value;
    } t_noise_rsp;

endpackage

// File: design/isre_noise.sv
// ---------------------------------------------------------------------------
// isre_noise
// lcg step followed by a remainder unit that folds the seed by
// powers of two; returns the offset accel sample as a 16-bit two's
// complement word
// ---------------------------------------------------------------------------
module isre_noise
    import isre_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_noise_req i_req,
    output t_noise_rsp o_rsp
);

    localparam logic N_IDLE = 1'b0;
    localparam logic N_REM  = 1'b1;

    logic                r_nstate;
    logic [C_SEED_W-1:0] r_seed;
    logic                r_done;
    logic [C_SEED_W-1:0] r_acc;
    logic [C_CNT_W-1:0]  r_cnt;
    logic                r_z;
    logic [C_WORD_W-1:0] r_value;

    logic [C_SEED_W-1:0] w_prod;
    logic [C_SEED_W-1:0] w_lcg;
    logic [C_SEED_W-1:0] w_fold;
    logic                w_z_ge;
    logic [C_WORD_W-1:0] w_z_rem;
    logic [C_WORD_W:0]   w_xy_sum;
    logic                w_xy_neg;
    logic                w_xy_ge;
    logic [C_WORD_W-1:0] w_xy_rem;
    logic [C_WORD_W-1:0] w_final;

    assign w_prod = r_seed * C_LCG_MUL;
    assign w_lcg  = w_prod + C_LCG_ADD;

    // z: high part times 47 plus low 11 bits keeps the value mod 2001
    assign w_fold = C_SEED_W'({{C_FOLD_SHIFT{1'b0}}, r_acc[C_SEED_W-1:C_FOLD_SHIFT]}
                              * C_FOLD_MUL)
                  + {{(C_SEED_W-C_FOLD_SHIFT){1'b0}}, r_acc[C_FOLD_SHIFT-1:0]};
    // after five folds the value is below twice the modulus
    assign w_z_ge  = w_fold >= {{(C_SEED_W-C_WORD_W){1'b0}}, C_Z_MOD};
    assign w_z_rem = w_z_ge ? C_WORD_W'(w_fold - {{(C_SEED_W-C_WORD_W){1'b0}}, C_Z_MOD})
                            : w_fold[C_WORD_W-1:0];

    // x and y: low 15 bits minus middle 15 bits plus top 2 bits, then one correction
    assign w_xy_sum = {{(C_WORD_W+1-C_XY_FOLD){1'b0}}, r_acc[C_XY_FOLD-1:0]}
                    - {{(C_WORD_W+1-C_XY_FOLD){1'b0}}, r_acc[2*C_XY_FOLD-1:C_XY_FOLD]}
                    + {{(C_WORD_W+1-(C_SEED_W-2*C_XY_FOLD)){1'b0}},
                       r_acc[C_SEED_W-1:2*C_XY_FOLD]};
    assign w_xy_neg = w_xy_sum[C_WORD_W];
    assign w_xy_ge  = !w_xy_neg && (w_xy_sum >= {1'b0, C_XY_MOD});
    assign w_xy_rem = w_xy_neg ? C_WORD_W'(w_xy_sum + {1'b0, C_XY_MOD})
                    : w_xy_ge  ? C_WORD_W'(w_xy_sum - {1'b0, C_XY_MOD})
                               : w_xy_sum[C_WORD_W-1:0];

    assign w_final = r_z ? C_WORD_W'(w_z_rem + C_Z_OFS)
                         : C_WORD_W'(w_xy_rem - C_XY_OFS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nstate <= N_IDLE;
            r_seed   <= C_SEED_RESET;
            r_done   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_nstate)
                N_IDLE: begin
                    if (i_req.start) begin
                        r_seed   <= w_lcg;
                        r_nstate <= N_REM;
                    end
                end
                N_REM: begin
                    if (r_cnt == C_CNT_LAST) begin
                        r_done   <= 1'b1;
                        r_nstate <= N_IDLE;
                    end
                end
                default: r_nstate <= N_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_nstate == N_IDLE) begin
            if (i_req.start) begin
                r_acc <= w_lcg;
                r_cnt <= '0;
                r_z   <= i_req.z_axis;
            end
        end else begin
            if (r_z) begin
                r_acc <= w_fold;
            end
            r_cnt <= C_CNT_W'(r_cnt + 1'b1);
            if (r_cnt == C_CNT_LAST) begin
                r_value <= w_final;
            end
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_value;

endmodule

// File: design/i2c_sensor_register_emulator.sv
// a result beat is registered and shown in the cycle after its input beat
// throughput: one beat per cycle for events that do not refresh the file, while the receiver does not stall
// a refresh holds off input for three lcg steps, each a multiply and then
//   the fold steps of the shared remainder unit
// reset (synchronous, active low) clears pointer and flag and reloads seed and address
// ---------------------------------------------------------------------------
// i2c_sensor_register_emulator
// i2c slave register file view of a temperature and accel sensor, with an
// auto-incrementing register pointer and lcg generated accel noise
// ---------------------------------------------------------------------------
module i2c_sensor_register_emulator
    import isre_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [C_ADDR_W-1:0] i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [C_OP_W-1:0]   i_operation,
    input  logic [C_ADDR_W-1:0] i_bus_address,
    input  logic                i_read_request,
    input  logic [C_BYTE_W-1:0] i_write_byte,
    input  logic [C_CODE_W-1:0] i_adc_code,
    input  logic [C_BYTE_W-1:0] i_frame_length,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_ack,
    output logic [C_BYTE_W-1:0] o_read_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_X    = 2'd1;
    localparam logic [1:0] S_Y    = 2'd2;
    localparam logic [1:0] S_Z    = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [C_BYTE_W-1:0] r_ptr, n_ptr;
    logic                r_loaded, n_loaded;
    logic [C_ADDR_W-1:0] r_addr;
    logic                r_out_valid;
    logic                r_ack;
    logic [C_BYTE_W-1:0] r_rdata;
    logic [C_BYTE_W-1:0] r_sample [C_FILE_BYTES];

    logic                w_accept;
    logic                w_refresh;
    logic                w_res_ack;
    logic [C_BYTE_W-1:0] w_res_data;
    logic                w_wr_en;
    logic [C_WIDX_W-1:0] w_wr_idx;
    logic [C_WORD_W-1:0] w_wr_word;
    t_noise_req          w_req;
    t_noise_rsp          w_rsp;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    // event decode and pointer update
    always_comb begin
        n_ptr      = r_ptr;
        n_loaded   = r_loaded;
        w_res_ack  = 1'b0;
        w_res_data = '0;
        w_refresh  = 1'b0;
        if (w_accept) begin
            case (i_operation)
                OP_CONNECT: begin
                    if (i_bus_address == r_addr) begin
                        n_loaded  = 1'b0;
                        w_res_ack = 1'b1;
                        w_refresh = i_read_request;
                    end
                end
                OP_READ: begin
                    if (|r_ptr[C_BYTE_W-1:C_IDX_W]) begin
                        w_res_data = C_PAST_END;
                    end else begin
                        w_res_data = r_sample[r_ptr[C_IDX_W-1:0]];
                        n_ptr      = C_BYTE_W'(r_ptr + 1'b1);
                    end
                end
                OP_WRITE: begin
                    if (!r_loaded) begin
                        if (!(|i_write_byte[C_BYTE_W-1:C_IDX_W])) begin
                            n_ptr     = i_write_byte;
                            n_loaded  = 1'b1;
                            w_res_ack = 1'b1;
                        end
                    end else begin
                        n_ptr     = C_BYTE_W'(r_ptr + 1'b1);
                        w_res_ack = 1'b1;
                    end
                end
                OP_DISCONNECT: n_loaded = 1'b0;
                OP_FRAME_END:  w_refresh = (i_frame_length != '0);
                default: ;
            endcase
        end
    end

    // refresh sequencer: temperature word, then x, y, z from the noise unit
    always_comb begin
        n_state      = r_state;
        w_req.start  = 1'b0;
        w_req.z_axis = 1'b0;
        w_wr_en      = 1'b0;
        w_wr_idx     = '0;
        w_wr_word    = w_rsp.value;
        case (r_state)
            S_IDLE: begin
                if (w_refresh) begin
                    w_wr_en     = 1'b1;
                    w_wr_word   = {{(C_WORD_W-C_CODE_W){1'b0}}, i_adc_code};
                    w_req.start = 1'b1;
                    n_state     = S_X;
                end
            end
            S_X: begin
                if (w_rsp.done) begin
                    w_wr_en     = 1'b1;
                    w_wr_idx    = C_WIDX_W'(1);
                    w_req.start = 1'b1;
                    n_state     = S_Y;
                end
            end
            S_Y: begin
                if (w_rsp.done) begin
                    w_wr_en      = 1'b1;
                    w_wr_idx     = C_WIDX_W'(2);
                    w_req.start  = 1'b1;
                    w_req.z_axis = 1'b1;
                    n_state      = S_Z;
                end
            end
            S_Z: begin
                if (w_rsp.done) begin
                    w_wr_en  = 1'b1;
                    w_wr_idx = C_WIDX_W'(3);
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    isre_noise u_noise (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= '0;
            r_loaded    <= 1'b0;
            r_addr      <= C_ADDR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_loaded <= n_loaded;
            if (i_cfg_we) begin
                r_addr <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ack   <= w_res_ack;
            r_rdata <= w_res_data;
        end
        // big-endian word into the byte file
        if (w_wr_en) begin
            r_sample[{w_wr_idx, 1'b0}] <= w_wr_word[C_WORD_W-1:C_BYTE_W];
            r_sample[{w_wr_idx, 1'b1}] <= w_wr_word[C_BYTE_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_ack       = r_ack;
    assign o_read_data = r_rdata;

endmodule

// File: design/isre_checker.sv
// ---------------------------------------------------------------------------
// isre_checker
// port-level checks of the register emulator, bound to the top level
// ---------------------------------------------------------------------------
module isre_checker
    import isre_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic [C_OP_W-1:0]   i_operation,
    input logic [C_BYTE_W-1:0] i_frame_length,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic                o_ack,
    input logic [C_BYTE_W-1:0] o_read_data
);

    logic w_in_beat;
    assign w_in_beat = i_in_valid && o_in_ready;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_ack) && $stable(o_read_data))
        else $error("result beat changed while stalled");

    // ack and read data never both carry information
    a_ack_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_ack |-> o_read_data == '0)
        else $error("ack with nonzero read data");

    // disconnect and unknown codes answer with an all-zero result
    a_quiet_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat && (i_operation == OP_DISCONNECT || i_operation > OP_FRAME_END)
        |=> o_out_valid && !o_ack && o_read_data == '0)
        else $error("nonzero result for a quiet operation");

    // a nonempty frame end starts a refresh, which holds off input
    a_refresh_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat && i_operation == OP_FRAME_END && i_frame_length != '0 |=> !o_in_ready)
        else $error("input ready during refresh");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind i2c_sensor_register_emulator isre_checker u_isre_checker (.*);

// File: bench/tb.sv
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the i2c sensor register emulator: a scoreboard
// tracks pointer, flag, lcg seed and register file, predicts ack and read
// data per input beat and compares every result beat in order; directed
// corner cases come first, then randomized bus transactions over four
// address settings with sender gaps and receiver stalls
// ---------------------------------------------------------------------------
module tb;
    import isre_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REFRESH_HOLD   = 120;
    localparam int PHASE_BEATS    = 110;
    localparam int WRAP_WRITES    = 252;

    localparam logic [C_OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [C_OP_W-1:0] OP_SPARE_HI = 3'd7;

    localparam logic [31:0] NOISE_MUL = 32'd1664525;
    localparam logic [31:0] NOISE_ADD = 32'd1013904223;
    localparam int          XY_SPAN   = 16384;
    localparam int          Z_SPAN    = 1000;
    localparam int          ONE_G     = 16384;

    typedef struct packed {
        logic [C_OP_W-1:0]   op;
        logic [C_ADDR_W-1:0] bus_address;
        logic                read_request;
        logic [C_BYTE_W-1:0] write_byte;
        logic [C_CODE_W-1:0] adc_code;
        logic [C_BYTE_W-1:0] frame_length;
    } t_bus_event;

    typedef struct packed {
        logic                ack;
        logic [C_BYTE_W-1:0] read_data;
    } t_reply;

    class sensor_scoreboard;
        logic [C_BYTE_W-1:0] file_bytes [C_FILE_BYTES];
        logic [C_BYTE_W-1:0] reg_ptr;
        logic                ptr_loaded;
        logic [31:0]         seed;
        logic [C_ADDR_W-1:0] own_address;
        t_reply              expected_replies [$];
        int unsigned         errors;

        function new();
            foreach (file_bytes[i]) file_bytes[i] = '0;
            reg_ptr     = '0;
            ptr_loaded  = 1'b0;
            seed        = 32'hDEADBEEF;
            own_address = 7'h68;
            errors      = 0;
        endfunction

        function int noise_in(int span);
            int unsigned modulus;
            int unsigned rem;
            seed    = seed * NOISE_MUL + NOISE_ADD;
            modulus = 2 * span + 1;
            rem     = seed % modulus;
            return int'(rem) - span;
        endfunction

        function void store_word(int at, logic [15:0] word);
            file_bytes[at]     = word[15:8];
            file_bytes[at + 1] = word[7:0];
        endfunction

        function void refresh_file(logic [C_CODE_W-1:0] code);
            int x;
            int y;
            int z;
            store_word(0, {2'b00, code});
            x = noise_in(XY_SPAN);
            store_word(2, x[15:0]);
            y = noise_in(XY_SPAN);
            store_word(4, y[15:0]);
            z = ONE_G + noise_in(Z_SPAN);
            store_word(6, z[15:0]);
        endfunction

        function void note_event(t_bus_event ev);
            t_reply r;
            r = '0;
            case (ev.op)
                OP_CONNECT: begin
                    if (ev.bus_address == own_address) begin
                        ptr_loaded = 1'b0;
                        if (ev.read_request) refresh_file(ev.adc_code);
                        r.ack = 1'b1;
                    end
                end
                OP_READ: begin
                    if (reg_ptr >= C_FILE_BYTES) begin
                        r.read_data = C_PAST_END;
                    end else begin
                        r.read_data = file_bytes[reg_ptr[C_IDX_W-1:0]];
                        reg_ptr     = reg_ptr + 1'b1;
                    end
                end
                OP_WRITE: begin
                    if (!ptr_loaded) begin
                        if (ev.write_byte < C_FILE_BYTES) begin
                            reg_ptr    = ev.write_byte;
                            ptr_loaded = 1'b1;
                            r.ack      = 1'b1;
                        end
                    end else begin
                        reg_ptr = reg_ptr + 1'b1;
                        r.ack   = 1'b1;
                    end
                end
                OP_DISCONNECT: ptr_loaded = 1'b0;
                OP_FRAME_END: begin
                    if (ev.frame_length != '0) refresh_file(ev.adc_code);
                end
                default: ;
            endcase
            expected_replies.push_back(r);
        endfunction

        function void check_reply(logic ack, logic [C_BYTE_W-1:0] data);
            t_reply want;
            if (expected_replies.size() == 0) begin
                $error("result beat with nothing expected: ack %0d read_data 0x%02h",
                       ack, data);
                errors++;
                return;
            end
            want = expected_replies.pop_front();
            if (ack !== want.ack) begin
                $error("ack: expected %0d, got %0d", want.ack, ack);
                errors++;
            end
            if (data !== want.read_data) begin
                $error("read_data: expected 0x%02h, got 0x%02h", want.read_data, data);
                errors++;
            end
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction
    endclass

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_cfg_we       = 1'b0;
    logic [C_ADDR_W-1:0] i_cfg_wdata    = '0;
    logic                i_in_valid     = 1'b0;
    logic                o_in_ready;
    logic [C_OP_W-1:0]   i_operation    = '0;
    logic [C_ADDR_W-1:0] i_bus_address  = '0;
    logic                i_read_request = 1'b0;
    logic [C_BYTE_W-1:0] i_write_byte   = '0;
    logic [C_CODE_W-1:0] i_adc_code     = '0;
    logic [C_BYTE_W-1:0] i_frame_length = '0;
    logic                o_out_valid;
    logic                i_out_ready    = 1'b0;
    logic                o_ack;
    logic [C_BYTE_W-1:0] o_read_data;

    sensor_scoreboard    sb;
    logic [C_ADDR_W-1:0] dev_addr  = C_ADDR_RESET;
    int                  gap_pct   = 0;
    int                  stall_pct = 0;
    int                  beats_sent = 0;
    int                  quiet_cycles = 0;

    i2c_sensor_register_emulator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_bus_address  (i_bus_address),
        .i_read_request (i_read_request),
        .i_write_byte   (i_write_byte),
        .i_adc_code     (i_adc_code),
        .i_frame_length (i_frame_length),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_ack          (o_ack),
        .o_read_data    (o_read_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // input beat is noted before the result check so a same-edge result still finds it
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                sb.note_event('{i_operation, i_bus_address, i_read_request,
                                i_write_byte, i_adc_code, i_frame_length});
            end
            if (o_out_valid && i_out_ready) sb.check_reply(o_ack, o_read_data);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $error("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic t_bus_event make_event(logic [C_OP_W-1:0] op,
                                              logic [C_ADDR_W-1:0] bus, logic rd,
                                              logic [C_BYTE_W-1:0] wb,
                                              logic [C_CODE_W-1:0] adc,
                                              logic [C_BYTE_W-1:0] flen);
        t_bus_event ev;
        ev.op           = op;
        ev.bus_address  = bus;
        ev.read_request = rd;
        ev.write_byte   = wb;
        ev.adc_code     = adc;
        ev.frame_length = flen;
        return ev;
    endfunction

    // unused fields are filled with random values too
    function automatic t_bus_event rand_event(logic [C_OP_W-1:0] op);
        return make_event(op, C_ADDR_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                          C_BYTE_W'($urandom_range(0, 255)),
                          C_CODE_W'($urandom_range(0, 16383)),
                          C_BYTE_W'($urandom_range(0, 255)));
    endfunction

    function automatic logic [C_ADDR_W-1:0] pick_address();
        if ($urandom_range(0, 99) < 85) return dev_addr;
        return C_ADDR_W'($urandom_range(0, 127));
    endfunction

    task automatic send_event(input t_bus_event ev);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= ev.op;
        i_bus_address  <= ev.bus_address;
        i_read_request <= ev.read_request;
        i_write_byte   <= ev.write_byte;
        i_adc_code     <= ev.adc_code;
        i_frame_length <= ev.frame_length;
        do @(posedge i_clk); while (!o_in_ready);
        beats_sent++;
    endtask

    task automatic drain_replies();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic set_device_address(input logic [C_ADDR_W-1:0] addr);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= addr;
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        sb.own_address = addr;
        dev_addr       = addr;
    endtask

    task automatic connect(input logic rd);
        t_bus_event ev;
        ev = rand_event(OP_CONNECT);
        ev.bus_address  = pick_address();
        ev.read_request = rd;
        send_event(ev);
    endtask

    task automatic write_transaction(input int extra);
        t_bus_event ev;
        connect(1'b0);
        ev = rand_event(OP_WRITE);
        if ($urandom_range(0, 99) < 85) ev.write_byte = C_BYTE_W'($urandom_range(0, 7));
        else ev.write_byte = C_BYTE_W'($urandom_range(8, 255));
        send_event(ev);
        repeat (extra) send_event(rand_event(OP_WRITE));
        if ($urandom_range(0, 99) < 80) send_event(rand_event(OP_DISCONNECT));
    endtask

    task automatic read_transaction();
        connect(1'b1);
        repeat ($urandom_range(1, 10)) send_event(rand_event(OP_READ));
        if ($urandom_range(0, 99) < 80) send_event(rand_event(OP_DISCONNECT));
    endtask

    task automatic run_traffic(input int count);
        int target;
        int pick;
        t_bus_event ev;
        target = beats_sent + count;
        while (beats_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                read_transaction();
            end else if (pick < 75) begin
                write_transaction($urandom_range(0, 3));
                if ($urandom_range(0, 1)) begin
                    repeat ($urandom_range(1, 4)) send_event(rand_event(OP_READ));
                end
            end else if (pick < 85) begin
                ev = rand_event(OP_FRAME_END);
                if ($urandom_range(0, 3) == 0) ev.frame_length = '0;
                send_event(ev);
            end else begin
                send_event(rand_event(C_OP_W'($urandom_range(0, 7))));
            end
        end
    endtask

    task automatic run_directed();
        // empty frame first, then a refresh so the file is written before any read
        send_event(make_event(OP_FRAME_END, '0, 1'b0, '0, '0, 8'h00));
        send_event(make_event(OP_FRAME_END, 7'h7F, 1'b1, 8'hFF, 14'h3FFF, 8'hFF));
        send_event(make_event(OP_CONNECT, C_ADDR_RESET - 1'b1, 1'b1, '0, '0, '0));
        // writes and reads with no matching connect before them
        send_event(make_event(OP_WRITE, '0, 1'b0, 8'd5, '0, '0));
        send_event(make_event(OP_WRITE, '0, 1'b0, 8'hFF, '0, '0));
        repeat (4) send_event(make_event(OP_READ, '0, 1'b0, '0, '0, '0));
        send_event(make_event(OP_DISCONNECT, '0, 1'b0, '0, '0, '0));
        // pointer byte out of range is refused
        send_event(make_event(OP_WRITE, '0, 1'b0, 8'd8, '0, '0));
        send_event(make_event(OP_WRITE, '0, 1'b0, 8'hFF, '0, '0));
        send_event(make_event(OP_CONNECT, C_ADDR_RESET, 1'b0, '0, 14'h3FFF, '0));
        send_event(make_event(OP_WRITE, '0, 1'b0, 8'd0, '0, '0));
        send_event(make_event(OP_DISCONNECT, '0, 1'b0, '0, '0, '0));
        send_event(make_event(OP_CONNECT, C_ADDR_RESET, 1'b1, '0, 14'h0000, '0));
        repeat (3) send_event(make_event(OP_READ, '0, 1'b0, '0, '0, '0));
        send_event(make_event(OP_SPARE_HI, 7'h7F, 1'b1, 8'hFF, 14'h3FFF, 8'hFF));
        send_event(make_event(OP_SPARE_LO, 7'h68, 1'b1, 8'h01, 14'h0001, 8'h01));
        send_event(make_event(OP_FRAME_END, '0, 1'b0, '0, 14'h0000, 8'h01));
        send_event(make_event(OP_CONNECT, 7'h00, 1'b0, '0, '0, '0));
        send_event(make_event(OP_CONNECT, 7'h7F, 1'b1, '0, '0, '0));
        send_event(make_event(OP_READ, '0, 1'b0, '0, '0, '0));
    endtask

    // later write bytes carry the pointer past 255 back into the file
    task automatic run_pointer_wrap();
        connect(1'b0);
        send_event(make_event(OP_WRITE, '0, 1'b0, 8'd7, '0, '0));
        repeat (WRAP_WRITES) send_event(rand_event(OP_WRITE));
        repeat (6) send_event(rand_event(OP_READ));
        send_event(rand_event(OP_DISCONNECT));
    endtask

    initial begin
        logic [C_ADDR_W-1:0] phase_addr [4];
        int                  phase_gap [4];
        int                  phase_stall [4];
        sb = new();
        phase_addr  = '{7'h00, 7'h7F, 7'(3 * $urandom_range(1, 41)), C_ADDR_RESET};
        phase_gap   = '{0, 49, 0, 38};
        phase_stall = '{0, 0, 49, 38};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        for (int p = 0; p < 4; p++) begin
            drain_replies();
            repeat (REFRESH_HOLD) @(posedge i_clk);
            set_device_address(phase_addr[p]);
            gap_pct   = phase_gap[p];
            stall_pct = phase_stall[p];
            if (p == 0) run_pointer_wrap();
            run_traffic(PHASE_BEATS / 2);
            drain_replies();
            run_traffic(PHASE_BEATS / 2);
        end
        drain_replies();
        repeat (REFRESH_HOLD) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/isre_pkg.sv
design/isre_noise.sv
design/i2c_sensor_register_emulator.sv
design/isre_checker.sv
bench/tb.sv
